### src/ccse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_pkg: shared types and constants
// word formats, character codes and the work descriptor passed from the
// lexer to the output serializer
// ----------------------------------------------------------------------------
package ccse_pkg;

   // character codes
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DQ    = 8'd34;
   localparam logic [7:0] CH_SQ    = 8'd39;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_BS    = 8'd92;
   localparam logic [7:0] CH_N     = 8'd110;

   // line break text is eight characters long
   localparam int unsigned BREAK_LEN = 8;
   localparam int unsigned BIDX_W    = $clog2(BREAK_LEN);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // tail of a word's output: nothing, one char, or backslash then char
   typedef enum logic [1:0] {
      PUT_NONE,
      PUT_CHAR,
      PUT_ESC
   } put_mode_type;

   // output work for one input byte, emitted in order slash, break, put
   typedef struct packed {
      logic         slash;
      logic         brk;
      put_mode_type put;
      logic [7:0]   ch;
   } desc_type;

   // quote, comma, newline, four spaces, quote
   function automatic logic [7:0] break_char(input logic [BIDX_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = CH_DQ;
         3'd1: c = CH_COMMA;
         3'd2: c = CH_LF;
         3'd7: c = CH_DQ;
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

endpackage

### src/ccse_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_lexer: comment stripping state machine
// tracks comments, literals, cr-lf pairs and space runs, and turns each
// accepted word into an output work descriptor
// ----------------------------------------------------------------------------
module ccse_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  ccse_pkg::req_type req_data,
   output logic              desc_valid,
   output ccse_pkg::desc_type desc
);

   typedef enum logic [3:0] {
      ST_BASE,
      ST_SL,
      ST_LINE,
      ST_BLK,
      ST_BSTAR,
      ST_STR,
      ST_STRE,
      ST_CHR,
      ST_CHRE
   } lex_state_type;

   lex_state_type state_ff, state_in;
   logic          lht_ff, lht_in;
   logic          pws_ff, pws_in;
   logic          pcr_ff, pcr_in;

   lex_state_type st, s;
   logic          lht, pws, pcr;
   logic [7:0]    c;
   logic          drop_lf, drop_sp, put, slash, brk, lht_n, in_lit;

   always_comb begin
      // a new file starts from a clean lexer
      st  = req_data.new_file ? ST_BASE : state_ff;
      lht = req_data.new_file ? 1'b0 : lht_ff;
      pws = req_data.new_file ? 1'b0 : pws_ff;
      pcr = req_data.new_file ? 1'b0 : pcr_ff;

      drop_lf = pcr && (req_data.in_byte == ccse_pkg::CH_LF);
      c       = (req_data.in_byte == ccse_pkg::CH_CR) ? ccse_pkg::CH_LF : req_data.in_byte;
      drop_sp = !drop_lf && (c == ccse_pkg::CH_SPACE) && pws;

      s     = st;
      put   = 1'b0;
      slash = 1'b0;
      brk   = 1'b0;
      lht_n = lht;

      case (st)
         ST_SL: begin
            if (c == ccse_pkg::CH_SLASH) begin
               s = ST_LINE;
            end else if (c == ccse_pkg::CH_STAR) begin
               s = ST_BLK;
            end else if (c == ccse_pkg::CH_LF) begin
               slash = 1'b1;
               brk   = 1'b1;
            end else begin
               slash = 1'b1;
               put   = 1'b1;
               if (c == ccse_pkg::CH_DQ) begin
                  s = ST_STR;
               end else if (c == ccse_pkg::CH_SQ) begin
                  s = ST_CHR;
               end else begin
                  s = ST_BASE;
               end
            end
         end
         ST_LINE: begin
            if (c == ccse_pkg::CH_LF) begin
               s     = ST_BASE;
               brk   = lht;
               lht_n = 1'b0;
            end
         end
         ST_BLK: begin
            if (c == ccse_pkg::CH_STAR) s = ST_BSTAR;
         end
         ST_BSTAR: begin
            s = (c == ccse_pkg::CH_SLASH) ? ST_BASE : ST_BLK;
         end
         ST_STR: begin
            if (c == ccse_pkg::CH_DQ) begin
               s = ST_BASE;
            end else if (c == ccse_pkg::CH_BS) begin
               s = ST_STRE;
            end
            put = 1'b1;
         end
         ST_STRE: begin
            s   = ST_STR;
            put = 1'b1;
         end
         ST_CHR: begin
            if (c == ccse_pkg::CH_SQ) begin
               s = ST_BASE;
            end else if (c == ccse_pkg::CH_BS) begin
               s = ST_CHRE;
            end
            put = 1'b1;
         end
         ST_CHRE: begin
            s   = ST_CHR;
            put = 1'b1;
         end
         default: begin
            s = ST_BASE;
            if (c == ccse_pkg::CH_SLASH) begin
               s = ST_SL;
            end else if (c == ccse_pkg::CH_LF) begin
               brk   = lht;
               lht_n = 1'b0;
            end else begin
               if (c == ccse_pkg::CH_DQ) begin
                  s = ST_STR;
               end else if (c == ccse_pkg::CH_SQ) begin
                  s = ST_CHR;
               end
               put = 1'b1;
            end
         end
      endcase

      if (put) lht_n = 1'b1;
      in_lit = (s == ST_STR) || (s == ST_STRE) || (s == ST_CHR) || (s == ST_CHRE);

      // descriptor for the serializer
      desc.slash = slash;
      desc.brk   = brk;
      if (!put) begin
         desc.put = ccse_pkg::PUT_NONE;
         desc.ch  = c;
      end else if (c == ccse_pkg::CH_LF) begin
         desc.put = ccse_pkg::PUT_ESC;
         desc.ch  = ccse_pkg::CH_N;
      end else if ((c == ccse_pkg::CH_DQ) || (c == ccse_pkg::CH_SQ)
                   || (c == ccse_pkg::CH_BS)) begin
         desc.put = ccse_pkg::PUT_ESC;
         desc.ch  = c;
      end else begin
         desc.put = ccse_pkg::PUT_CHAR;
         desc.ch  = c;
      end
      desc_valid = !drop_lf && !drop_sp && (slash || brk || put);

      // next state
      state_in = state_ff;
      lht_in   = lht_ff;
      pws_in   = pws_ff;
      pcr_in   = pcr_ff;
      if (take) begin
         if (drop_lf) begin
            pcr_in = 1'b0;
         end else if (drop_sp) begin
            pcr_in = 1'b0;
         end else begin
            state_in = s;
            lht_in   = lht_n;
            pws_in   = (c == ccse_pkg::CH_SPACE) && !in_lit;
            pcr_in   = (req_data.in_byte == ccse_pkg::CH_CR);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BASE;
         lht_ff   <= 1'b0;
         pws_ff   <= 1'b0;
         pcr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         lht_ff   <= lht_in;
         pws_ff   <= pws_in;
         pcr_ff   <= pcr_in;
      end
   end

endmodule

### src/ccse_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_emitter: output serializer
// one staging slot and one active job; the job is sent one character per
// handshake, slash first, then the line break text, then the escaped char
// ----------------------------------------------------------------------------
module ccse_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ccse_pkg::desc_type push_desc,
   output logic               stage_full,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ccse_pkg::rsp_type  rsp_data
);

   ccse_pkg::desc_type               stage_ff, stage_in;
   logic                             stage_vld_ff, stage_vld_in;
   ccse_pkg::desc_type               job_ff, job_in;
   logic [ccse_pkg::BIDX_W-1:0]      bidx_ff, bidx_in;

   logic busy, last, fire, job_done;
   logic [7:0] cur;

   assign busy = job_ff.slash || job_ff.brk || (job_ff.put != ccse_pkg::PUT_NONE);

   always_comb begin
      // current character and whether it closes the word's output
      if (job_ff.slash) begin
         cur  = ccse_pkg::CH_SLASH;
         last = !job_ff.brk && (job_ff.put == ccse_pkg::PUT_NONE);
      end else if (job_ff.brk) begin
         cur  = ccse_pkg::break_char(bidx_ff);
         last = (bidx_ff == ccse_pkg::BIDX_W'(ccse_pkg::BREAK_LEN - 1))
                && (job_ff.put == ccse_pkg::PUT_NONE);
      end else begin
         case (job_ff.put)
            ccse_pkg::PUT_ESC: begin
               cur  = ccse_pkg::CH_BS;
               last = 1'b0;
            end
            default: begin
               cur  = job_ff.ch;
               last = 1'b1;
            end
         endcase
      end
   end

   assign fire     = busy && rsp_ready;
   assign job_done = !busy || (fire && last);

   always_comb begin
      job_in       = job_ff;
      bidx_in      = bidx_ff;
      stage_in     = stage_ff;
      stage_vld_in = stage_vld_ff;

      if (fire && !last) begin
         if (job_ff.slash) begin
            job_in.slash = 1'b0;
         end else if (job_ff.brk) begin
            if (bidx_ff == ccse_pkg::BIDX_W'(ccse_pkg::BREAK_LEN - 1)) job_in.brk = 1'b0;
            bidx_in = bidx_ff + 1'b1;
         end else begin
            job_in.put = ccse_pkg::PUT_CHAR;
         end
      end

      if (job_done) begin
         bidx_in = '0;
         if (stage_vld_ff) begin
            job_in       = stage_ff;
            stage_vld_in = 1'b0;
         end else if (push) begin
            job_in = push_desc;
         end else begin
            job_in.slash = 1'b0;
            job_in.brk   = 1'b0;
            job_in.put   = ccse_pkg::PUT_NONE;
         end
      end else if (push) begin
         stage_in     = push_desc;
         stage_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.slash <= 1'b0;
         job_ff.brk   <= 1'b0;
         job_ff.put   <= ccse_pkg::PUT_NONE;
         job_ff.ch    <= '0;
         bidx_ff      <= '0;
         stage_vld_ff <= 1'b0;
      end else begin
         job_ff.slash <= job_in.slash;
         job_ff.brk   <= job_in.brk;
         job_ff.put   <= job_in.put;
         job_ff.ch    <= job_in.ch;
         bidx_ff      <= bidx_in;
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_full        = stage_vld_ff;
   assign rsp_valid         = busy;
   assign rsp_data.out_byte = cur;
   assign rsp_data.last     = last;

   // staging slot only fills behind a job that is still running
   a_stage_behind_job: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff |-> busy)
      else $error("staging slot full with no active job");

   // break index only moves while the line break text is being sent
   a_bidx_in_break: assert property (@(posedge clock) disable iff (reset)
      (bidx_ff != '0) |-> job_ff.brk)
      else $error("break index set outside line break");

   // a finished job with nothing waiting leaves the output idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && last && !stage_vld_ff && !push) |=> !busy)
      else $error("output still valid after last character");

   // no push is offered while the staging slot is occupied
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff |-> !push)
      else $error("push into full staging slot");

endmodule

### src/c_comment_strip_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_strip_escaper: c comment stripper and string escaper
// takes c source a word (byte) at a time, removes comments, folds cr-lf and
// space runs, and emits the kept text escaped as string-literal content
// ----------------------------------------------------------------------------
//
//   channel | dir | ports                        | word
//   --------+-----+------------------------------+---------------------------
//   req     | in  | req_valid req_ready req_data | in_byte, new_file
//   rsp     | out | rsp_valid rsp_ready rsp_data | out_byte, last
//
// - one input word per cycle when it makes at most one output character and
//   rsp_ready stays high; a word that makes n characters holds the output for
//   n handshakes (up to 9: pending slash, then eight character line break)
// - the lexer state machine updates in the accept cycle; its descriptor goes
//   straight into the output job register, or into a one-word staging slot
//   when the job register is still busy
// - req_ready is low only while the staging slot is full; it does not depend
//   on rsp_ready in the same cycle
// - a stall on rsp holds the current character and last flag unchanged
// - synchronous active-high reset clears lexer state, job and staging slot;
//   words dropped by the lexer (lf after cr, repeated space) make no output
//
module c_comment_strip_escaper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ccse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ccse_pkg::rsp_type rsp_data
);

   logic               take;
   logic               desc_valid;
   ccse_pkg::desc_type desc;
   logic               stage_full;

   // accept whenever the staging slot has room
   assign req_ready = !stage_full;
   assign take      = req_valid && req_ready;

   // lexer: comment / literal state machine and descriptor build
   ccse_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_data   (req_data),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   // serializer: expands each descriptor into output characters
   ccse_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .push       (take && desc_valid),
      .push_desc  (desc),
      .stage_full (stage_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### tb/sv/c_comment_strip_escaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_strip_escaper_tb: self-checking bench for the comment stripper
// feeds c source words (directed corner cases, then random files built from
// tokens plus noise), predicts the escaped transcript in a scoreboard and
// checks every output word in order, with random idling on both channels and
// one long receiver hold-off that backs the block up into its input
// ----------------------------------------------------------------------------
module c_comment_strip_escaper_tb;

   localparam int unsigned LIMIT_CYCLES = 500000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned HOLD_AT_WORD = 150;
   localparam int unsigned CALM_LEFT    = 50;   // last words sent with no idling
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned MAX_REPORTS  = 10;

   // lexer states of the predictor
   typedef enum logic [3:0] {
      LX_BASE,
      LX_SLASH,
      LX_LINE_CMT,
      LX_BLOCK_CMT,
      LX_BLOCK_STAR,
      LX_STRING,
      LX_STRING_ESC,
      LX_CHAR,
      LX_CHAR_ESC
   } lex_state_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ccse_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ccse_pkg::rsp_type rsp_data;

   c_comment_strip_escaper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // source words waiting to be sent, and escaped words still to arrive
   ccse_pkg::req_type source_q[$];
   ccse_pkg::rsp_type transcript_q[$];
   logic [7:0]        char_buf[$];

   // predictor state
   lex_state_type cur_lex    = LX_BASE;
   bit            line_dirty = 1'b0;
   bit            space_seen = 1'b0;
   bit            cr_seen    = 1'b0;

   int unsigned   words_in    = 0;
   int unsigned   words_out   = 0;
   int unsigned   mismatches  = 0;
   int unsigned   file_count  = 0;
   int unsigned   cycle_count = 0;
   int unsigned   gap_left    = 0;
   int unsigned   stall_left  = 0;
   int unsigned   hold_left   = 0;
   bit            hold_active = 1'b0;
   bit            hold_done   = 1'b0;

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_word(input logic [7:0] b, input bit first);
      source_q.push_back(ccse_pkg::req_type'{in_byte: b, new_file: first});
      if (first) file_count++;
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) add_word(s[i], 1'b0);
   endfunction

   function automatic logic [7:0] pick_letter();
      return ($urandom_range(0, 3) == 0) ? 8'(8'd48 + $urandom_range(0, 9))
                                         : 8'(8'd97 + $urandom_range(0, 25));
   endfunction

   // mostly letters, now and then any byte at all
   function automatic logic [7:0] pick_any();
      return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : pick_letter();
   endfunction

   function automatic void add_eol();
      case ($urandom_range(0, 2))
         0: add_word(ccse_pkg::CH_LF, 1'b0);
         1: add_word(ccse_pkg::CH_CR, 1'b0);
         default: begin
            add_word(ccse_pkg::CH_CR, 1'b0);
            add_word(ccse_pkg::CH_LF, 1'b0);
         end
      endcase
   endfunction

   // one character of literal body: escapes, embedded newlines, other quote
   function automatic void add_lit_char(input logic [7:0] other_quote);
      case ($urandom_range(0, 9))
         0: begin
            add_word(ccse_pkg::CH_BS, 1'b0);
            add_word(pick_any(), 1'b0);
         end
         1: add_word(($urandom_range(0, 1) != 0) ? ccse_pkg::CH_LF : ccse_pkg::CH_CR,
                     1'b0);
         2: add_word(other_quote, 1'b0);
         3: add_word(ccse_pkg::CH_SPACE, 1'b0);
         default: add_word(pick_letter(), 1'b0);
      endcase
   endfunction

   function automatic void add_literal(input logic [7:0] quote, input int unsigned len);
      logic [7:0] other;
      other = (quote == ccse_pkg::CH_DQ) ? ccse_pkg::CH_SQ : ccse_pkg::CH_DQ;
      add_word(quote, 1'b0);
      repeat (len) add_lit_char(other);
      add_word(quote, 1'b0);
   endfunction

   // a file of well-formed tokens with some noise and broken pieces mixed in
   function automatic void add_file(input int unsigned len);
      int unsigned start;
      logic [7:0]  specials[8];
      string       punct;
      start    = source_q.size();
      specials = '{ccse_pkg::CH_SLASH, ccse_pkg::CH_STAR, ccse_pkg::CH_DQ,
                   ccse_pkg::CH_SQ, ccse_pkg::CH_BS, ccse_pkg::CH_CR,
                   ccse_pkg::CH_LF, ccse_pkg::CH_SPACE};
      punct    = ";(){}=+-,<>";
      add_word(pick_letter(), 1'b1);
      while (source_q.size() - start < len) begin
         case ($urandom_range(0, 11))
            0, 1: repeat ($urandom_range(1, 6)) add_word(pick_letter(), 1'b0);
            2: repeat ($urandom_range(1, 4)) add_word(ccse_pkg::CH_SPACE, 1'b0);
            3: add_literal(ccse_pkg::CH_DQ, $urandom_range(0, 6));
            4: add_literal(ccse_pkg::CH_SQ, $urandom_range(1, 2));
            5: begin
               add_text("//");
               repeat ($urandom_range(0, 5)) add_word(pick_any(), 1'b0);
               add_eol();
            end
            6: begin
               add_text("/*");
               repeat ($urandom_range(0, 5))
                  add_word(($urandom_range(0, 2) == 0) ? ccse_pkg::CH_STAR : pick_any(),
                           1'b0);
               add_text("*/");
            end
            7: add_eol();
            8: begin
               // slash as an operator: before a space, a newline or a quote
               add_word(ccse_pkg::CH_SLASH, 1'b0);
               case ($urandom_range(0, 4))
                  0: add_word(ccse_pkg::CH_SPACE, 1'b0);
                  1: add_word(ccse_pkg::CH_LF, 1'b0);
                  2: add_word(ccse_pkg::CH_CR, 1'b0);
                  3: add_literal(ccse_pkg::CH_DQ, $urandom_range(0, 3));
                  default: add_literal(ccse_pkg::CH_SQ, 1);
               endcase
            end
            9: repeat ($urandom_range(1, 3)) add_word(8'($urandom_range(0, 255)), 1'b0);
            10: add_word(specials[$urandom_range(0, 7)], 1'b0);
            default: add_word(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // predictor: lexer step for one accepted word, pushes the escaped words
   // ------------------------------------------------------------------------
   function automatic void add_break();
      char_buf = {char_buf, ccse_pkg::CH_DQ, ccse_pkg::CH_COMMA, ccse_pkg::CH_LF,
                  ccse_pkg::CH_SPACE, ccse_pkg::CH_SPACE, ccse_pkg::CH_SPACE,
                  ccse_pkg::CH_SPACE, ccse_pkg::CH_DQ};
   endfunction

   function automatic void predict_escape(input ccse_pkg::req_type w);
      logic [7:0]    c;
      lex_state_type s;
      bit            emit_text;
      c         = w.in_byte;
      emit_text = 1'b0;
      char_buf  = {};
      if (w.new_file) begin
         cur_lex    = LX_BASE;
         line_dirty = 1'b0;
         space_seen = 1'b0;
         cr_seen    = 1'b0;
      end
      // lf of a cr-lf pair vanishes without touching anything else
      if (cr_seen && c == ccse_pkg::CH_LF) begin
         cr_seen = 1'b0;
         return;
      end
      cr_seen = (c == ccse_pkg::CH_CR);
      if (c == ccse_pkg::CH_CR) c = ccse_pkg::CH_LF;
      if (c == ccse_pkg::CH_SPACE && space_seen) return;

      s = cur_lex;
      case (s)
         LX_SLASH: begin
            if (c == ccse_pkg::CH_SLASH) s = LX_LINE_CMT;
            else if (c == ccse_pkg::CH_STAR) s = LX_BLOCK_CMT;
            else if (c == ccse_pkg::CH_LF) begin
               // slash then newline: both go out, state stays after slash
               char_buf.push_back(ccse_pkg::CH_SLASH);
               add_break();
            end else begin
               char_buf.push_back(ccse_pkg::CH_SLASH);
               if (c == ccse_pkg::CH_DQ) s = LX_STRING;
               else if (c == ccse_pkg::CH_SQ) s = LX_CHAR;
               else s = LX_BASE;
               emit_text = 1'b1;
            end
         end
         LX_LINE_CMT: begin
            if (c == ccse_pkg::CH_LF) begin
               s = LX_BASE;
               if (line_dirty) add_break();
               line_dirty = 1'b0;
            end
         end
         LX_BLOCK_CMT: if (c == ccse_pkg::CH_STAR) s = LX_BLOCK_STAR;
         LX_BLOCK_STAR: s = (c == ccse_pkg::CH_SLASH) ? LX_BASE : LX_BLOCK_CMT;
         LX_STRING: begin
            if (c == ccse_pkg::CH_DQ) s = LX_BASE;
            else if (c == ccse_pkg::CH_BS) s = LX_STRING_ESC;
            emit_text = 1'b1;
         end
         LX_STRING_ESC: begin
            s = LX_STRING;
            emit_text = 1'b1;
         end
         LX_CHAR: begin
            if (c == ccse_pkg::CH_SQ) s = LX_BASE;
            else if (c == ccse_pkg::CH_BS) s = LX_CHAR_ESC;
            emit_text = 1'b1;
         end
         LX_CHAR_ESC: begin
            s = LX_CHAR;
            emit_text = 1'b1;
         end
         default: begin
            s = LX_BASE;
            if (c == ccse_pkg::CH_SLASH) s = LX_SLASH;
            else if (c == ccse_pkg::CH_LF) begin
               if (line_dirty) add_break();
               line_dirty = 1'b0;
            end else begin
               if (c == ccse_pkg::CH_DQ) s = LX_STRING;
               else if (c == ccse_pkg::CH_SQ) s = LX_CHAR;
               emit_text = 1'b1;
            end
         end
      endcase

      if (emit_text) begin
         line_dirty = 1'b1;
         if (c == ccse_pkg::CH_LF) char_buf = {char_buf, ccse_pkg::CH_BS, ccse_pkg::CH_N};
         else begin
            if (c == ccse_pkg::CH_DQ || c == ccse_pkg::CH_SQ || c == ccse_pkg::CH_BS)
               char_buf.push_back(ccse_pkg::CH_BS);
            char_buf.push_back(c);
         end
      end

      cur_lex    = s;
      space_seen = (c == ccse_pkg::CH_SPACE) && !(s >= LX_STRING && s <= LX_CHAR_ESC);
      foreach (char_buf[i])
         transcript_q.push_back(ccse_pkg::rsp_type'{out_byte: char_buf[i],
                                                    last: (i == char_buf.size() - 1)});
   endfunction

   // ------------------------------------------------------------------------
   // driver: one word offered at a time, random gaps between words
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (source_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= source_q.pop_front();
            // keep offering during the hold-off so the block backs up
            if (!hold_active && source_q.size() >= CALM_LEFT && $urandom_range(0, 9) == 0)
               gap_left <= $urandom_range(1, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stall bursts, plus the long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_done   <= 1'b0;
         hold_left   <= 0;
      end else if (hold_active) begin
         if (hold_left <= 1) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b1;
         end
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_in >= HOLD_AT_WORD) begin
         hold_active <= 1'b1;
         hold_left   <= HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_active) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (source_q.size() >= CALM_LEFT && $urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 19);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predict on every accepted source word, then check output words
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      ccse_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_escape(req_data);
            words_in <= words_in + 1;
         end
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (transcript_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected output word %0d: byte %h last %b",
                           words_out, rsp_data.out_byte, rsp_data.last);
            end else begin
               want = transcript_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"mismatch at output word %0d: expected byte %h last %b,",
                               " got byte %h last %b"},
                              words_out, want.out_byte, want.last,
                              rsp_data.out_byte, rsp_data.last);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d output words still due",
                  cycle_count, transcript_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      // directed corner cases
      add_word(8'hFF, 1'b1);           // all ones, opens a file
      add_text("  /");                 // space run, then a slash
      add_word(ccse_pkg::CH_CR, 1'b0); // slash then cr as newline
      add_word(ccse_pkg::CH_LF, 1'b0); // lf of the cr-lf pair dropped
      add_text("/\"\\\"");             // second slash opens a line comment; quotes are comment text
      add_word(ccse_pkg::CH_LF, 1'b0); // newline ends the line comment
      add_text("\"'\\''");             // opens a string holding quotes and an escape
      add_text(" //");                 // space and slashes inside the string
      add_word(ccse_pkg::CH_CR, 1'b0);
      add_text("/**x*/");              // comment marks as string text
      add_word(8'h00, 1'b0);           // all zeros
      add_text("/");                   // slash in the open string, which the next file abandons

      // random files
      while (source_q.size() < 400) add_file($urandom_range(15, 60));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (source_q.size() != 0 || req_valid) @(posedge clock);
      while (transcript_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (transcript_q.size() != 0) mismatches++;

      $display("covered %0d source files: %0d words in, %0d escaped words out",
               file_count, words_in, words_out);
      $display("one receiver hold-off of %0d cycles, %0d mismatches",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
